[rtl/bitmap_first_free_allocator_core_macros.svh]
// assertion macros shared by the allocator checkers
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_CORE_MACROS_SVH

// clocked assertion, switched off while reset is held
`define BFFA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also watches reset itself
`define BFFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bffa_pkg.sv]
// shared types and constants of the first-fit bitmap allocator
package bffa_pkg;

  localparam int MAP_BYTES_DEF = 128;

  localparam int IDX_W   = 10;
  localparam int LIMIT_W = 11;
  localparam int FUNC_W  = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
  localparam int                 INDEX_SPAN  = 1024;

  // operation codes; the spare code acts as test
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd2;

  // register select bit of paddr: register 0 is entry_limit
  localparam logic REG_ENTRY_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RMW,
    S_RESP
  } state_e;

  // one result, result_index in the low bits
  typedef struct packed {
    logic              is_allocated;
    status_e           status;
    logic [IDX_W-1:0]  result_index;
  } resp_t;

endpackage

[rtl/bffa_map_ram.sv]
// byte-wide allocation map memory, one write and one registered read port
module bffa_map_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bffa_engine.sv]
// sequencer: clearing pass, first-fit scan and read-modify-write of the map
module bffa_engine #(
  parameter int MAP_BYTES = 128,
  parameter int AW        = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bffa_pkg::LIMIT_W-1:0]   lim_i,
  input  logic                           in_valid_i,
  input  logic [bffa_pkg::FUNC_W-1:0]    in_func_i,
  input  logic [bffa_pkg::IDX_W-1:0]     in_index_i,
  output logic                           in_ready_o,
  output logic                           res_valid_o,
  output bffa_pkg::resp_t                res_o,
  input  logic                           res_take_i,
  output logic                           mem_we_o,
  output logic [AW-1:0]                  mem_waddr_o,
  output logic [7:0]                     mem_wdata_o,
  output logic [AW-1:0]                  mem_raddr_o,
  input  logic [7:0]                     mem_rdata_i
);

  import bffa_pkg::*;

  state_e                state_q, state_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [AW-1:0]         byte_q, byte_d;
  logic [FUNC_W-1:0]     func_q, func_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  resp_t                 res_q, res_d;

  logic                  in_acc;
  logic                  clr_last;
  logic                  zero_found;
  logic [2:0]            zero_pos;
  logic [LIMIT_W-1:0]    scan_base;
  logic [LIMIT_W-1:0]    scan_entry;
  logic                  scan_hit;
  logic                  scan_last;
  logic                  rmw_bit;
  logic [7:0]            rmw_mask;
  logic [7:0]            scan_mask;

  assign in_acc   = in_valid_i && in_ready_o;
  assign clr_last = (clr_q == AW'(MAP_BYTES - 1));

  // lowest clear entry of the byte, bit 7 first
  always_comb begin
    zero_found = 1'b0;
    zero_pos   = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (!zero_found && !mem_rdata_i[7-i]) begin
        zero_found = 1'b1;
        zero_pos   = 3'(i);
      end
    end
  end

  assign scan_base  = LIMIT_W'(byte_q) << 3;
  assign scan_entry = scan_base | LIMIT_W'(zero_pos);
  assign scan_hit   = zero_found && (scan_entry < lim_i);
  assign scan_last  = (scan_base + LIMIT_W'(8)) >= lim_i;
  assign scan_mask  = 8'h80 >> zero_pos;

  assign rmw_mask = 8'h80 >> idx_q[2:0];
  assign rmw_bit  = |(mem_rdata_i & rmw_mask);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_func_i == FUNC_ALLOC) begin
            state_d = (lim_i == '0) ? S_RESP : S_SCAN;
          end else begin
            state_d = (LIMIT_W'(in_index_i) >= lim_i) ? S_RESP : S_RMW;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_last) state_d = S_RESP;
      end
      S_RMW: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (res_take_i) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(idx_q >> 3);
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = byte_q + AW'(1);
    clr_d       = clr_q;
    byte_d      = byte_q;
    func_d      = func_q;
    idx_d       = idx_q;
    res_d       = res_q;
    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = 8'h00;
        clr_d       = clr_q + AW'(1);
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_func_i == FUNC_ALLOC) begin
          mem_raddr_o = '0;
        end else begin
          mem_raddr_o = AW'(in_index_i >> 3);
        end
        if (in_acc) begin
          func_d = in_func_i;
          idx_d  = in_index_i;
          byte_d = '0;
          if (in_func_i == FUNC_ALLOC) begin
            res_d = '{is_allocated: 1'b0, status: ST_FULL, result_index: '0};
          end else begin
            res_d = '{is_allocated: 1'b0, status: ST_RANGE, result_index: in_index_i};
          end
        end
      end
      S_SCAN: begin
        // next byte is read ahead while this one is checked
        byte_d = byte_q + AW'(1);
        if (scan_hit) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = byte_q;
          mem_wdata_o = mem_rdata_i | scan_mask;
          res_d = '{is_allocated: 1'b1, status: ST_OK,
                    result_index: scan_entry[IDX_W-1:0]};
        end else begin
          res_d = '{is_allocated: 1'b0, status: ST_FULL, result_index: '0};
        end
      end
      S_RMW: begin
        if (func_q == FUNC_FREE) begin
          if (rmw_bit) begin
            mem_we_o    = 1'b1;
            mem_wdata_o = mem_rdata_i & ~rmw_mask;
            res_d = '{is_allocated: 1'b0, status: ST_OK, result_index: idx_q};
          end else begin
            res_d = '{is_allocated: 1'b0, status: ST_NOT_ALLOC, result_index: idx_q};
          end
        end else begin
          res_d = '{is_allocated: rmw_bit, status: ST_OK, result_index: idx_q};
        end
      end
      S_RESP: begin
        res_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    func_q <= func_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
  end

endmodule

[rtl/bitmap_first_free_allocator_core.sv]
// top level of the first-fit bitmap allocator
//
// Requests enter on the s_axis channel: tuser carries func (allocate, free,
// test), tdata carries entry_index. Each request gives exactly one result on
// the m_axis channel: result_index, status and is_allocated in tdata.
// Requests are handled one at a time. Free and test read the map byte,
// modify it into the result register and pass the result on to the output
// register; an index out of range skips the map read. A new request is taken
// only once the last result has moved into the output register. Allocate
// scans the map one byte per cycle through the single memory read port and
// stops at the first byte with a clear entry below the limit in force; in the
// worst case it reads every byte within that limit. A zero limit skips the scan.
// The limit in force is the smallest of entry_limit, 8 * MAP_BYTES and 1024.
// After reset the map memory is cleared one byte per cycle while
// s_axis_tready stays low; the APB port works throughout.
// A result that waits on a stalled receiver sits in the output register;
// the next request is still taken and worked on, and holds in the core until
// the output register frees up. entry_limit is to be written over APB by the user only while
// the block is idle; the block does not enforce it. Reads return its value.
module bitmap_first_free_allocator_core #(
  parameter int MAP_BYTES = bffa_pkg::MAP_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] entry_index, [15:10] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  // result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [9:0] result_index, [11:10] status,
                                      // [12] is_allocated, [15:13] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import bffa_pkg::*;

  localparam int AW     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CapInt = (8 * MAP_BYTES > INDEX_SPAN) ? INDEX_SPAN : 8 * MAP_BYTES;
  localparam logic [LIMIT_W-1:0] Cap = LIMIT_W'(CapInt);

  logic [LIMIT_W-1:0] entry_limit_q, entry_limit_d;
  logic [LIMIT_W-1:0] lim;
  logic               cfg_wr;

  logic               m_valid_q, m_valid_d;
  resp_t              m_data_q, m_data_d;

  logic               res_valid;
  resp_t              res;
  logic               res_take;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [7:0]         mem_rdata;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRY_LIMIT);
  assign entry_limit_d = cfg_wr ? pwdata[LIMIT_W-1:0] : entry_limit_q;
  assign prdata = (paddr[2] == REG_ENTRY_LIMIT) ? {{(32-LIMIT_W){1'b0}}, entry_limit_q}
                                                 : 32'h0;

  assign lim = (entry_limit_q > Cap) ? Cap : entry_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_limit_q <= LIMIT_RESET;
    end else begin
      entry_limit_q <= entry_limit_d;
    end
  end

  bffa_engine #(
    .MAP_BYTES (MAP_BYTES),
    .AW        (AW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (lim),
    .in_valid_i  (s_axis_tvalid),
    .in_func_i   (s_axis_tuser),
    .in_index_i  (s_axis_tdata[IDX_W-1:0]),
    .in_ready_o  (s_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  bffa_map_ram #(
    .DEPTH (MAP_BYTES),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign res_take = res_valid && (!m_valid_q || m_axis_tready);

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (res_take) begin
      m_valid_d = 1'b1;
      m_data_d  = res;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_data_q};

endmodule

[rtl/bffa_checker.sv]
// port-level checks of the allocator, bound to the top level
`include "bitmap_first_free_allocator_core_macros.svh"

module bffa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  import bffa_pkg::*;

  logic s_acc;
  logic m_stall;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign m_stall = m_axis_tvalid && !m_axis_tready;

  // a stalled result stays put
  `BFFA_ASSERT(a_m_hold, clk_i, rst_ni, m_stall |=> m_axis_tvalid && $stable(m_axis_tdata),
               "result changed while stalled")

  // one request at a time: ready drops after a request is taken
  `BFFA_ASSERT(a_one_at_a_time, clk_i, rst_ni, s_acc |=> !s_axis_tready,
               "request taken while busy")

  // a result never shows up in the cycle right after a request is taken
  `BFFA_ASSERT(a_min_latency, clk_i, rst_ni, s_acc && !m_axis_tvalid |=> !m_axis_tvalid,
               "result too early")

  // the map clearing pass holds off requests through reset
  `BFFA_ASSERT_ALWAYS(a_reset_clear, clk_i, !rst_ni |=> !s_axis_tready,
                      "request taken during map clear")

endmodule

bind bitmap_first_free_allocator_core bffa_checker u_bffa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
